// File: hw/rtl/ukl_pkg.sv
// Shared types and the key canonicalization function for the unordered key list.
package ukl_pkg;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_FIND   = 2'd2,
      OP_CLEAR  = 2'd3
   } ukl_op_type;

   typedef struct packed {
      ukl_op_type  opcode;
      logic [63:0] key_low;
      logic [15:0] key_high;
   } ukl_req_type;

   typedef struct packed {
      logic       success;
      logic [4:0] entry_count;
      logic       is_empty;
      logic       is_full;
   } ukl_rsp_type;

   typedef struct packed {
      logic [63:0] lo;
      logic [15:0] hi;
   } ukl_key_type;

   typedef struct packed {
      logic cmp;    // capture the compare result against the broadcast key
      logic load;   // take the broadcast key
      logic shift;  // take the key of the next cell up
   } ukl_cell_ctl_type;

   // A key ends at its first zero byte; every byte after it is forced to zero.
   function automatic ukl_key_type ukl_canon(input logic [63:0] lo, input logic [15:0] hi);
      logic        alive;
      logic [79:0] k;
      ukl_key_type r;
      k     = {hi, lo};
      alive = 1'b1;
      for (int b = 0; b < 10; b++) begin
         alive = alive & (k[8*b +: 8] != 8'h00);
         if (!alive) begin
            k[8*b +: 8] = 8'h00;
         end
      end
      r.lo = k[63:0];
      r.hi = k[79:64];
      return r;
   endfunction

endpackage

// File: hw/rtl/ukl_cell.sv
// One storage cell of the key list: holds a key, compares it, and shifts down.
module ukl_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  ukl_pkg::ukl_cell_ctl_type ctl,
   input  logic                      valid,
   input  ukl_pkg::ukl_key_type      bcast_key,
   input  ukl_pkg::ukl_key_type      upper_key,
   output ukl_pkg::ukl_key_type      key,
   output logic                      match
);

   ukl_pkg::ukl_key_type key_ff;
   logic                 match_ff;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         key_ff <= bcast_key;
      end else if (ctl.shift) begin
         key_ff <= upper_key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else if (ctl.cmp) begin
         match_ff <= valid && (key_ff == bcast_key);
      end
   end

   assign key   = key_ff;
   assign match = match_ff;

endmodule

// File: hw/rtl/unordered_key_list.sv
// Top level of the unordered key list: a row of key cells under a small controller.
//
//   channel   ports                      handshake
//   request   start, busy, req_item      taken when start is high and busy is low
//   response  rsp_valid, rsp_item        one-cycle strobe, cannot be held off
//
// Every request passes through three steps: capture, compare in all cells at once,
// then apply (append, shift down, or clear). The response strobes in the cycle
// after apply, in which busy is already low and a new request may be taken.
// Synchronous reset empties the list; stored keys are not cleared.
module unordered_key_list #(
   parameter int DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  ukl_pkg::ukl_req_type req_item,
   output logic                 rsp_valid,
   output ukl_pkg::ukl_rsp_type rsp_item
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_CMP, ST_APPLY} state_type;

   state_type              state_ff;
   ukl_pkg::ukl_op_type    op_ff;
   ukl_pkg::ukl_key_type   key_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic                   ok_in;
   logic                   rsp_valid_ff;
   ukl_pkg::ukl_rsp_type   rsp_ff;

   logic [DEPTH-1:0]       match_vec;
   logic [DEPTH-1:0]       prefix_vec;
   ukl_pkg::ukl_key_type   cell_key [DEPTH];
   logic                   any_match;
   logic                   is_full_now;
   logic                   do_remove;

   assign any_match   = |match_vec;
   assign is_full_now = (count_ff == CNT_W'(DEPTH));
   assign do_remove   = (state_ff == ST_APPLY) && (op_ff == ukl_pkg::OP_REMOVE) && any_match;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      ukl_pkg::ukl_cell_ctl_type ctl;
      ukl_pkg::ukl_key_type      upper;

      // A cell moves down when the first match sits at or below it.
      assign prefix_vec[i] = |match_vec[i:0];
      assign ctl.cmp   = (state_ff == ST_CMP);
      assign ctl.load  = (state_ff == ST_APPLY) && (op_ff == ukl_pkg::OP_INSERT)
                         && !is_full_now && (count_ff == CNT_W'(i));
      assign ctl.shift = do_remove && prefix_vec[i];

      if (i == DEPTH - 1) begin : g_top
         assign upper = cell_key[i];
      end else begin : g_mid
         assign upper = cell_key[i+1];
      end

      ukl_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .valid     (count_ff > CNT_W'(i)),
         .bcast_key (key_ff),
         .upper_key (upper),
         .key       (cell_key[i]),
         .match     (match_vec[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      ok_in    = 1'b0;
      case (op_ff)
         ukl_pkg::OP_INSERT: begin
            ok_in = !is_full_now;
            if (!is_full_now) begin
               count_in = count_ff + 1'b1;
            end
         end
         ukl_pkg::OP_REMOVE: begin
            ok_in = any_match;
            if (any_match) begin
               count_in = count_ff - 1'b1;
            end
         end
         ukl_pkg::OP_FIND: begin
            ok_in = any_match;
         end
         ukl_pkg::OP_CLEAR: begin
            ok_in    = 1'b1;
            count_in = '0;
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  op_ff    <= req_item.opcode;
                  key_ff   <= ukl_pkg::ukl_canon(req_item.key_low, req_item.key_high);
                  state_ff <= ST_CMP;
               end
            end
            ST_CMP: begin
               state_ff <= ST_APPLY;
            end
            ST_APPLY: begin
               count_ff             <= count_in;
               rsp_valid_ff         <= 1'b1;
               rsp_ff.success       <= ok_in;
               rsp_ff.entry_count   <= 5'(count_in);
               rsp_ff.is_empty      <= (count_in == '0);
               rsp_ff.is_full       <= (count_in == CNT_W'(DEPTH));
               state_ff             <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count above depth");

   a_rsp_after_apply: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_APPLY))
      else $error("response without an apply cycle");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_remove_one: assert property (@(posedge clock) disable iff (reset)
      do_remove |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("successful remove did not drop the count by one");

endmodule
